// ===== rtl/k_way_merge_assert.svh =====
// Assertion macros shared by the k_way_merge RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef K_WAY_MERGE_ASSERT_SVH
`define K_WAY_MERGE_ASSERT_SVH

// Clocked assertion, held off while reset is asserted
`define KWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define KWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/kwm_pkg.sv =====
// Shared types and constants for the k_way_merge block.
// No dependencies; used by k_way_merge and its testbench.
package kwm_pkg;

  // default sizing
  localparam int LANES_DEF       = 8;
  localparam int VALUE_WIDTH_DEF = 64;

  // fixed port field widths
  localparam int LANE_FIELD_W  = 3;
  localparam int VALUE_FIELD_W = 64;
  localparam int CFG_W         = 4;

  // active lane count after reset
  localparam logic [CFG_W-1:0] ACT_LANES_RST = 4'd8;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_LAST,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/k_way_merge.sv =====
// k_way_merge top level: head bookkeeping, min-search sequencer, output register.
// Depends on kwm_pkg, kwm_ram and k_way_merge_assert.svh.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, lane_i, value_i,          | input
//           | end_of_lane_i                                    |
//   out     | out_valid_o/out_ready_i, merged_value_o,         | output
//           | source_lane_o, stream_end_o                      |
//   cfg     | cfg_valid_i/cfg_ready_o, cfg_data_i (active lanes)| input
//
// Ignored transaction (idle, full or finished lane): stays idle; taken, set incomplete:
// check, then idle. Set complete: check, scan of the N effective active lanes, one lane
// per cycle through the single compare unit on the head RAM read port, last, emit; end marker: check, emit.
// The result sits in an output register; a stalled output holds the sequencer
// in its emit step, and in_ready_o is low until the result is loaded.
// Reset clears valid/done bits and sets active lanes to 8; no clearing pass.
`include "k_way_merge_assert.svh"

module k_way_merge #(
  parameter int LANES       = kwm_pkg::LANES_DEF,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transactions
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kwm_pkg::LANE_FIELD_W-1:0]  lane_i,
  input  logic [kwm_pkg::VALUE_FIELD_W-1:0] value_i,
  input  logic                              end_of_lane_i,
  // output transactions
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kwm_pkg::VALUE_FIELD_W-1:0] merged_value_o,
  output logic [kwm_pkg::LANE_FIELD_W-1:0]  source_lane_o,
  output logic                              stream_end_o,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kwm_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int LANE_W = $clog2(LANES);
  localparam int CNT_W  = $clog2(LANES + 1);

  kwm_pkg::state_e state_q, state_d;

  logic [kwm_pkg::CFG_W-1:0] act_lanes_q;
  logic [CNT_W-1:0]          eff_n;
  logic [31:0]               raw_ext;
  logic [LANES-1:0]          act_mask;

  logic [LANES-1:0] head_valid_q, head_valid_d;
  logic [LANES-1:0] lane_done_q, lane_done_d;

  logic [LANE_W-1:0]      rd_idx_q, rd_idx_d;
  logic [LANE_W-1:0]      cmp_idx_q;
  logic                   cmp_vld_q;
  logic [LANE_W-1:0]      best_idx_q, best_idx_d;
  logic [VALUE_WIDTH-1:0] best_val_q, best_val_d;
  logic                   best_vld_q, best_vld_d;
  logic                   end_pend_q, end_pend_d;

  logic                            out_valid_q;
  logic [kwm_pkg::VALUE_FIELD_W-1:0] out_value_q;
  logic [kwm_pkg::LANE_FIELD_W-1:0]  out_lane_q;
  logic                            out_end_q;

  logic                   in_acc;
  logic                   lane_ok;
  logic [LANE_W-1:0]      lane_idx;
  logic                   take;
  logic                   ram_we;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   all_ready;
  logic                   any_valid;
  logic                   last_idx;
  logic                   load_out;

  // configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_lanes_q <= kwm_pkg::ACT_LANES_RST;
    end else if (cfg_valid_i) begin
      act_lanes_q <= cfg_data_i;
    end
  end

  // effective lane count: zero acts as one, clamp at LANES
  always_comb begin
    raw_ext = 32'(act_lanes_q);
    if (raw_ext == 32'd0) begin
      eff_n = CNT_W'(1);
    end else if (raw_ext > 32'(LANES)) begin
      eff_n = CNT_W'(LANES);
    end else begin
      eff_n = CNT_W'(raw_ext);
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      act_mask[i] = (32'(i) < 32'(eff_n));
    end
  end

  // input decode: idle, full and finished lanes are dropped
  assign in_ready_o = (state_q == kwm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign lane_ok    = (32'(lane_i) < 32'(eff_n));
  assign lane_idx   = LANE_W'(lane_i);
  assign take       = in_acc && lane_ok && !head_valid_q[lane_idx] && !lane_done_q[lane_idx];
  assign ram_we     = take && !end_of_lane_i;

  // head value storage
  kwm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LANES)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lane_idx),
    .wdata_i (VALUE_WIDTH'(value_i)),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  // every active lane holds a head or is done; any head present
  assign all_ready = &(head_valid_q | lane_done_q | ~act_mask);
  assign any_valid = |(head_valid_q & act_mask);
  assign last_idx  = ((32'(rd_idx_q) + 32'd1) == 32'(eff_n));
  assign load_out  = (state_q == kwm_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

  // sequencer and shared compare unit
  always_comb begin
    state_d      = state_q;
    head_valid_d = head_valid_q;
    lane_done_d  = lane_done_q;
    rd_idx_d     = rd_idx_q;
    best_idx_d   = best_idx_q;
    best_val_d   = best_val_q;
    best_vld_d   = best_vld_q;
    end_pend_d   = end_pend_q;

    // compare the head read in the previous cycle
    if (cmp_vld_q && head_valid_q[cmp_idx_q]) begin
      if (!best_vld_q || ($signed(rd_data) < $signed(best_val_q))) begin
        best_val_d = rd_data;
        best_idx_d = cmp_idx_q;
        best_vld_d = 1'b1;
      end
    end

    case (state_q)
      kwm_pkg::ST_IDLE: begin
        if (take) begin
          if (end_of_lane_i) begin
            lane_done_d[lane_idx] = 1'b1;
          end else begin
            head_valid_d[lane_idx] = 1'b1;
          end
          state_d = kwm_pkg::ST_CHECK;
        end
      end
      kwm_pkg::ST_CHECK: begin
        rd_idx_d   = '0;
        best_vld_d = 1'b0;
        end_pend_d = 1'b0;
        if (!all_ready) begin
          state_d = kwm_pkg::ST_IDLE;
        end else if (!any_valid) begin
          end_pend_d = 1'b1;
          state_d    = kwm_pkg::ST_EMIT;
        end else begin
          state_d = kwm_pkg::ST_SCAN;
        end
      end
      kwm_pkg::ST_SCAN: begin
        if (last_idx) begin
          state_d = kwm_pkg::ST_LAST;
        end else begin
          rd_idx_d = rd_idx_q + LANE_W'(1);
        end
      end
      kwm_pkg::ST_LAST: begin
        state_d = kwm_pkg::ST_EMIT;
      end
      kwm_pkg::ST_EMIT: begin
        if (load_out) begin
          if (!end_pend_q) begin
            head_valid_d[best_idx_q] = 1'b0;
          end
          state_d = kwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kwm_pkg::ST_IDLE;
      head_valid_q <= '0;
      lane_done_q  <= '0;
      cmp_vld_q    <= 1'b0;
      best_vld_q   <= 1'b0;
      end_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_valid_q <= head_valid_d;
      lane_done_q  <= lane_done_d;
      cmp_vld_q    <= (state_q == kwm_pkg::ST_SCAN);
      best_vld_q   <= best_vld_d;
      end_pend_q   <= end_pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= rd_idx_q;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    if (load_out) begin
      if (end_pend_q) begin
        out_value_q <= '0;
        out_lane_q  <= '0;
        out_end_q   <= 1'b1;
      end else begin
        out_value_q <= kwm_pkg::VALUE_FIELD_W'($signed(best_val_q));
        out_lane_q  <= kwm_pkg::LANE_FIELD_W'(best_idx_q);
        out_end_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_value_q;
  assign source_lane_o  = out_lane_q;
  assign stream_end_o   = out_end_q;

  // emitted lane loses its head
  `KWM_ASSERT(a_emit_clears_head, load_out && !end_pend_q |=> !head_valid_q[$past(best_idx_q)], "emitted head still valid")
  // at most one head is added per transaction
  `KWM_ASSERT(a_one_head_per_txn, 1'b1 |=> $countones(head_valid_q) <= $countones($past(head_valid_q)) + 1, "more than one head added")
  // output register never overwritten while a result is waiting
  `KWM_ASSERT_ALWAYS(a_no_overwrite, load_out |-> (!out_valid_q || out_ready_i), "pending result overwritten")
  // done marks only ever set
  `KWM_ASSERT(a_done_sticky, 1'b1 |=> (lane_done_q & $past(lane_done_q)) == $past(lane_done_q), "lane done mark cleared")

endmodule

// ===== rtl/kwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-lane head values of k_way_merge.
module kwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/tb_k_way_merge.sv =====
// Self-checking testbench for k_way_merge: queued stimulus, handshake driver and result checker.
// Depends on kwm_pkg and the k_way_merge RTL only.
module tb_k_way_merge;

  localparam int LANES         = kwm_pkg::LANES_DEF;
  localparam int CFG_W         = kwm_pkg::CFG_W;
  localparam int LANE_FIELD_W  = kwm_pkg::LANE_FIELD_W;
  localparam int VALUE_FIELD_W = kwm_pkg::VALUE_FIELD_W;
  localparam int ITEM_TARGET = 1600;     // merge-relevant input transactions
  localparam int SETTLE      = 24;       // quiet cycles before a register write
  localparam int TAIL_CYCLES = 40;
  localparam int LIMIT       = 600000;
  localparam int IDLE_PCT    = 21;

  localparam logic [CFG_W-1:0]         LANES_AFTER_RESET = 4'd8;
  localparam logic signed [63:0]       VMIN = {1'b1, 63'b0};
  localparam logic signed [63:0]       VMAX = {1'b0, {63{1'b1}}};

  typedef enum bit {TXN_DATA, TXN_CFG} txn_kind_e;

  // one queued input or register-write transaction
  typedef struct packed {
    txn_kind_e                kind;
    logic [LANE_FIELD_W-1:0]  lane;
    logic [VALUE_FIELD_W-1:0] value;
    logic                     eol;
    logic [CFG_W-1:0]         cfg;
  } stim_txn_t;

  // merge bookkeeping: active count, head valid / done bits, heads
  typedef struct packed {
    logic [CFG_W-1:0]                   lanes;
    logic [LANES-1:0]                   vld;
    logic [LANES-1:0]                   fin;
    logic [LANES-1:0][VALUE_FIELD_W-1:0] head;
  } merge_state_t;

  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] value;
    logic [LANE_FIELD_W-1:0]  lane;
    logic                     last;
  } merge_out_t;

  typedef struct packed {
    merge_state_t st;
    bit           taken;   // item changed lane state (not ignored)
    bit           emits;
    merge_out_t   res;
  } merge_res_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [LANE_FIELD_W-1:0]   lane_i = '0;
  logic [VALUE_FIELD_W-1:0]  value_i = '0;
  logic                      end_of_lane_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [VALUE_FIELD_W-1:0]  merged_value_o;
  logic [LANE_FIELD_W-1:0]   source_lane_o;
  logic                      stream_end_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_W-1:0]          cfg_data_i = '0;

  stim_txn_t          pending [$];
  merge_out_t         merge_due [$];
  merge_state_t       plan_st;      // generator's view, advanced at queue time
  merge_state_t       live_st;      // checker's view, advanced on accepted transactions
  logic signed [63:0] tail [LANES]; // last value sent per lane

  int taken_cnt;
  int err_cnt;
  int fed_cnt;
  int quiet_cnt;
  int drained;
  int hold_left;
  bit held_once;
  int skipped_cnt;
  int checked_cnt;
  int end_cnt;
  int cfg_cnt;
  int cyc_cnt;

  k_way_merge dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .lane_i        (lane_i),
    .value_i       (value_i),
    .end_of_lane_i (end_of_lane_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .merged_value_o(merged_value_o),
    .source_lane_o (source_lane_o),
    .stream_end_o  (stream_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Merge predictor
  // ---------------------------------------------------------------------------

  function automatic merge_state_t reset_state();
    merge_state_t st;
    st = '0;
    st.lanes = LANES_AFTER_RESET;
    return st;
  endfunction

  // out-of-range counts clamp to 1..LANES
  function automatic int active_span(logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (int'(c) > LANES) return LANES;
    return int'(c);
  endfunction

  function automatic merge_res_t merge_step(merge_state_t st, logic [LANE_FIELD_W-1:0] lane,
                                            logic signed [63:0] value, logic eol);
    merge_res_t r;
    int         n;
    int         best;
    bit         any;
    r = '0;
    r.st = st;
    n = active_span(st.lanes);
    best = 0;
    any = 1'b0;
    // idle, finished or full lane: nothing happens
    if (int'(lane) >= n || st.fin[lane] || st.vld[lane]) return r;
    r.taken = 1'b1;
    if (eol) begin
      r.st.fin[lane] = 1'b1;
    end else begin
      r.st.head[lane] = value;
      r.st.vld[lane] = 1'b1;
    end
    // every active lane must be done or hold a head; lowest lane wins ties
    for (int i = 0; i < n; i++) begin
      if (!r.st.vld[i] && !r.st.fin[i]) return r;
      if (r.st.vld[i]) begin
        if (!any || $signed(r.st.head[i]) < $signed(r.st.head[best])) best = i;
        any = 1'b1;
      end
    end
    r.emits = 1'b1;
    if (any) begin
      r.res.value = r.st.head[best];
      r.res.lane = best[LANE_FIELD_W-1:0];
      r.st.vld[best] = 1'b0;
    end else begin
      r.res.last = 1'b1;
    end
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("tb: mismatch: %s", msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_data(int lane, logic signed [63:0] v, bit eol);
    stim_txn_t  t;
    merge_res_t r;
    t = '0;
    t.kind = TXN_DATA;
    t.lane = lane[LANE_FIELD_W-1:0];
    t.value = v;
    t.eol = eol;
    pending.push_back(t);
    r = merge_step(plan_st, t.lane, v, eol);
    plan_st = r.st;
    if (r.taken) taken_cnt++;
  endtask

  task automatic push_cfg(logic [CFG_W-1:0] c);
    stim_txn_t t;
    t = '0;
    t.kind = TXN_CFG;
    t.cfg = c;
    pending.push_back(t);
    plan_st.lanes = c;
  endtask

  // mostly refill a lane that needs a value; otherwise random noise
  task automatic gen_step(bit narrow, bit closing);
    int                 n;
    int                 needy [$];
    int                 ln;
    int                 pick;
    logic signed [63:0] v;
    bit                 eol;
    n = active_span(plan_st.lanes);
    for (int i = 0; i < n; i++)
      if (!plan_st.vld[i] && !plan_st.fin[i]) needy.push_back(i);
    if (needy.size() == 0 || $urandom_range(0, 99) < 12) begin
      ln = $urandom_range(0, LANES - 1);
      v = {$urandom, $urandom};
      eol = 1'($urandom_range(0, 1));
      // stray end marks must not kill live lanes before the closing phase
      if (!closing && ln < n && !plan_st.vld[ln] && !plan_st.fin[ln]) eol = 1'b0;
    end else begin
      ln = needy[$urandom_range(0, needy.size() - 1)];
      eol = closing && ($urandom_range(0, 99) < 6);
      pick = $urandom_range(0, 99);
      if (narrow) v = 64'($urandom_range(0, 7));
      else if (pick < 3) v = VMIN;
      else if (pick < 6) v = VMAX;
      else if (pick < 18) v = {$urandom, $urandom};
      else if (pick < 28) v = tail[ln];
      else v = tail[ln] + 64'($urandom_range(1, 5000));
      if (!eol) tail[ln] = v;
    end
    push_data(ln, v, eol);
  endtask

  // ---------------------------------------------------------------------------
  // Input / register-write driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : feed_proc
    bit        in_go;
    bit        cfg_go;
    bit        nxt_in_valid;
    bit        nxt_cfg_valid;
    bit        calm;
    stim_txn_t nxt;
    if (rst_ni) begin
      in_go  = in_valid_i && in_ready_o;
      cfg_go = cfg_valid_i && cfg_ready_o;
      nxt_in_valid  = in_valid_i && !in_go;
      nxt_cfg_valid = cfg_valid_i && !cfg_go;
      if (in_go) fed_cnt++;
      // quiet time since the last transaction on any channel
      if (in_go || cfg_go || (out_valid_o && out_ready_i)) quiet_cnt = 0;
      else if (quiet_cnt < SETTLE) quiet_cnt++;
      calm = (fed_cnt >= 700 && fed_cnt < 1000);
      if (!nxt_in_valid && !nxt_cfg_valid && pending.size() != 0) begin
        nxt = pending[0];
        if (nxt.kind == TXN_CFG) begin
          // register writes only once the block has drained and settled
          if (quiet_cnt >= SETTLE && merge_due.size() == 0) begin
            cfg_data_i <= nxt.cfg;
            nxt_cfg_valid = 1'b1;
            void'(pending.pop_front());
          end
        end else if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
          lane_i        <= nxt.lane;
          value_i       <= nxt.value;
          end_of_lane_i <= nxt.eol;
          nxt_in_valid = 1'b1;
          void'(pending.pop_front());
        end
      end
      in_valid_i  <= nxt_in_valid;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, one long hold-off, one calm stretch
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drain_proc
    bit calm;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) drained++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held_once && drained >= 400) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      calm = (drained >= 650 && drained < 950);
      out_ready_i <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: predict on accepted inputs, compare accepted results in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    merge_res_t r;
    merge_out_t want;
    if (!rst_ni) begin
      live_st = reset_state();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        live_st.lanes = cfg_data_i;
        cfg_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (merge_due.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: value %h lane %0d end %b",
                                  merged_value_o, source_lane_o, stream_end_o));
        end else begin
          want = merge_due.pop_front();
          checked_cnt++;
          if (want.last) end_cnt++;
          if (merged_value_o !== want.value)
            note_mismatch($sformatf("merged_value %h, expected %h", merged_value_o, want.value));
          if (source_lane_o !== want.lane)
            note_mismatch($sformatf("source_lane %0d, expected %0d", source_lane_o, want.lane));
          if (stream_end_o !== want.last)
            note_mismatch($sformatf("stream_end %b, expected %b", stream_end_o, want.last));
        end
      end
      if (in_valid_i && in_ready_o) begin
        r = merge_step(live_st, lane_i, value_i, end_of_lane_i);
        live_st = r.st;
        if (!r.taken) skipped_cnt++;
        if (r.emits) merge_due.push_back(r.res);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin : watchdog_proc
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build stimulus, release reset, drain, report
  // ---------------------------------------------------------------------------
  initial begin : stim_proc
    int               pick;
    int               steps;
    bit               narrow;
    logic [CFG_W-1:0] cfg_v;
    plan_st = reset_state();
    for (int i = 0; i < LANES; i++) tail[i] = $signed({$urandom, $urandom}) >>> 20;

    // reset count of 8: a lone head waits, full-lane items are dropped
    push_data(7, 64'sd5, 1'b0);
    push_data(7, 64'sd9, 1'b0);
    push_data(7, {$urandom, $urandom}, 1'b1);
    // count 0 behaves as one lane: lane 0 values go straight out, other lanes are idle
    push_cfg(4'd0);
    push_data(0, VMIN, 1'b0);
    push_data(0, VMAX, 1'b0);
    push_data(0, -64'sd1, 1'b0);
    push_data(3, 64'sd1, 1'b0);
    push_data(7, 64'sd2, 1'b0);
    // two lanes: tie, full lane, lane end, finished lane, end marker
    push_cfg(4'd2);
    push_data(0, 64'sd10, 1'b0);
    push_data(0, 64'sd3, 1'b0);
    push_data(1, 64'sd10, 1'b0);
    push_data(0, 64'sd20, 1'b0);
    push_data(1, {$urandom, $urandom}, 1'b1);
    push_data(1, 64'sd4, 1'b0);
    push_data(0, VMAX, 1'b0);
    push_data(0, {$urandom, $urandom}, 1'b1);
    push_data(0, 64'sd7, 1'b0);
    push_data(1, {$urandom, $urandom}, 1'b1);

    // random phases over several active counts, lane 7 head brought back in
    while (taken_cnt < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cfg_v = 4'd8;
      else if (pick < 55) cfg_v = 4'd15;
      else if (pick < 65) cfg_v = 4'($urandom_range(9, 14));
      else if (pick < 90) cfg_v = 4'($urandom_range(3, 7));
      else cfg_v = 4'($urandom_range(0, 2));
      push_cfg(cfg_v);
      narrow = ($urandom_range(0, 99) < 20);
      steps = (cfg_v < 3) ? 12 : $urandom_range(40, 160);
      repeat (steps) gen_step(narrow, 1'b0);
    end

    // closing: all lanes, end them one by one until the final end marker
    push_cfg(4'(LANES));
    while (plan_st.fin != '1) gen_step(1'b0, 1'b1);
    repeat (6) gen_step(1'b0, 1'b1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i || cfg_valid_i) @(posedge clk_i);
    while (merge_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    foreach (merge_due[i])
      note_mismatch($sformatf("missing result: value %h lane %0d end %b",
                              merge_due[i].value, merge_due[i].lane, merge_due[i].last));

    $display("tb: %0d input transactions (%0d dropped as idle/full/finished lane), %0d writes",
             fed_cnt, skipped_cnt, cfg_cnt);
    $display("tb: %0d results checked, %0d end markers, %0d mismatches",
             checked_cnt, end_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
